// File: sv/lkt_pkg.sv
// Shared constants, types and state encoding for the keyed entry table.
// Used by the top level, the key store and the testbench; no dependencies.
package lkt_pkg;

    localparam int ENTRIES = 16;
    localparam int KEY_W   = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W   = IDX_W;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LRU,
        ST_TOUCH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// File: sv/lkt_key_ram.sv
// Key store: one write port and one registered read port.
// Depends on lkt_pkg for its depth, widths and request struct.
module lkt_key_ram (
    input  logic                    i_clk,
    input  lkt_pkg::t_ram_req       i_req,
    output logic [lkt_pkg::KEY_W-1:0] o_rdata
);

    logic [lkt_pkg::KEY_W-1:0] r_mem [lkt_pkg::ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

// File: sv/lru_keyed_entry_table_top.sv
// Top level of the fully associative keyed entry table with LRU replacement.
// Depends on lkt_pkg and instantiates lkt_key_ram for the key store.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata = key[63:0]; tuser = opcode
//  m_axis    out        tdata = slot[3:0], zero padded to 8 bits; tuser = hit, replaced
//
// One item is worked on at a time; o_s_axis_tready is high only while the sequencer idles.
// A lookup reads the key store one slot per cycle through its registered read port and one
// 64-bit comparator, stopping at the first match, the first empty slot or the last slot.
// An insert into a free slot goes straight to the update of the ages; an insert into a full
// table first walks the ages with one magnitude comparator to find the victim.
// Reset (synchronous, active low) empties the table at once through its valid bits.
// A finished result waits in the output register while the next item is accepted; the
// sequencer only stalls in its final state if that register is still occupied.
module lru_keyed_entry_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] key
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] slot, [7:4] zero
    output logic [1:0]  o_m_axis_tuser    // [0] hit, [1] replaced
);

    localparam int IW = lkt_pkg::IDX_W;
    localparam int AW = lkt_pkg::AGE_W;
    localparam int CW = lkt_pkg::CNT_W;
    localparam int N  = lkt_pkg::ENTRIES;

    lkt_pkg::t_state r_state, n_state;

    logic                      r_op, n_op;
    logic [lkt_pkg::KEY_W-1:0] r_key, n_key;
    logic [IW-1:0]             r_idx, n_idx;
    logic [IW-1:0]             r_cmp_idx, n_cmp_idx;
    logic                      r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]             r_slot, n_slot;
    logic                      r_hit, n_hit;
    logic                      r_repl, n_repl;
    logic                      r_nolim, n_nolim;
    logic [N-1:0]              r_valid, n_valid;
    logic [AW-1:0]             r_age [N];
    logic [AW-1:0]             n_age [N];
    logic [CW-1:0]             r_fill, n_fill;

    logic                      r_out_valid, n_out_valid;
    logic [IW-1:0]             r_out_slot, n_out_slot;
    logic                      r_out_hit, n_out_hit;
    logic                      r_out_repl, n_out_repl;

    lkt_pkg::t_ram_req         w_ram_req;
    logic [lkt_pkg::KEY_W-1:0] w_rdata;
    logic                      w_accept;
    logic                      w_match;
    logic                      w_scan_end;
    logic                      w_lru_end;
    logic                      w_out_free;
    logic                      w_not_full;

    lkt_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == lkt_pkg::ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_not_full      = (r_fill < CW'(N));

    // The comparator sees the slot that was addressed in the cycle before.
    assign w_match    = r_cmp_vld && r_valid[r_cmp_idx] && (w_rdata == r_key);
    assign w_scan_end = r_cmp_vld && (!r_valid[r_cmp_idx] || (r_cmp_idx == IW'(N - 1)));
    assign w_lru_end  = (r_idx == IW'(N - 1));

    always_comb begin
        w_ram_req.we    = (r_state == lkt_pkg::ST_TOUCH) && (r_op == lkt_pkg::OP_INSERT);
        w_ram_req.waddr = r_slot;
        w_ram_req.wdata = r_key;
        w_ram_req.raddr = r_idx;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lkt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_axis_tuser == lkt_pkg::OP_LOOKUP) begin
                        n_state = lkt_pkg::ST_SCAN;
                    end else if (w_not_full) begin
                        n_state = lkt_pkg::ST_TOUCH;
                    end else begin
                        n_state = lkt_pkg::ST_LRU;
                    end
                end
            end
            lkt_pkg::ST_SCAN: begin
                if (w_match) begin
                    n_state = lkt_pkg::ST_TOUCH;
                end else if (w_scan_end) begin
                    n_state = lkt_pkg::ST_DONE;
                end
            end
            lkt_pkg::ST_LRU: begin
                if (w_lru_end) begin
                    n_state = lkt_pkg::ST_TOUCH;
                end
            end
            lkt_pkg::ST_TOUCH: begin
                n_state = lkt_pkg::ST_DONE;
            end
            lkt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = lkt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lkt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result register.
    always_comb begin
        n_op        = r_op;
        n_key       = r_key;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_repl      = r_repl;
        n_nolim     = r_nolim;
        n_valid     = r_valid;
        n_age       = r_age;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_slot  = r_out_slot;
        n_out_hit   = r_out_hit;
        n_out_repl  = r_out_repl;

        unique case (r_state)
            lkt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op      = i_s_axis_tuser;
                    n_key     = i_s_axis_tdata;
                    n_hit     = 1'b0;
                    n_repl    = 1'b0;
                    n_nolim   = 1'b0;
                    n_cmp_vld = 1'b0;
                    n_slot    = '0;
                    n_idx     = '0;
                    if (i_s_axis_tuser == lkt_pkg::OP_INSERT) begin
                        if (w_not_full) begin
                            // Every other valid slot ages by one.
                            n_slot  = r_fill[IW-1:0];
                            n_nolim = 1'b1;
                        end else begin
                            // Slot zero is the first candidate; the walk starts at one.
                            n_idx  = IW'(1);
                            n_repl = 1'b1;
                        end
                    end
                end
            end
            lkt_pkg::ST_SCAN: begin
                n_cmp_idx = r_idx;
                n_cmp_vld = 1'b1;
                if (r_idx != IW'(N - 1)) begin
                    n_idx = r_idx + IW'(1);
                end
                if (w_match) begin
                    n_slot = r_cmp_idx;
                    n_hit  = 1'b1;
                end
            end
            lkt_pkg::ST_LRU: begin
                // The first slot holding the highest age wins.
                if (r_age[r_idx] > r_age[r_slot]) begin
                    n_slot = r_idx;
                end
                if (!w_lru_end) begin
                    n_idx = r_idx + IW'(1);
                end
            end
            lkt_pkg::ST_TOUCH: begin
                for (int i = 0; i < N; i++) begin
                    if ((IW'(i) != r_slot) && r_valid[i]
                        && (r_nolim || (r_age[i] < r_age[r_slot]))) begin
                        n_age[i] = r_age[i] + AW'(1);
                    end
                end
                n_age[r_slot] = '0;
                if (r_op == lkt_pkg::OP_INSERT) begin
                    n_valid[r_slot] = 1'b1;
                    if (r_nolim) begin
                        n_fill = r_fill + CW'(1);
                    end
                end
            end
            lkt_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_slot  = r_slot;
                    n_out_hit   = r_hit;
                    n_out_repl  = r_repl;
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lkt_pkg::ST_IDLE;
            r_valid     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cmp_vld   <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_cmp_vld   <= n_cmp_vld;
            r_age       <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_cmp_idx  <= n_cmp_idx;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_repl     <= n_repl;
        r_nolim    <= n_nolim;
        r_out_slot <= n_out_slot;
        r_out_hit  <= n_out_hit;
        r_out_repl <= n_out_repl;
    end

    // The slot field carries the low four bits of the slot number.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_slot};
    assign o_m_axis_tuser  = {r_out_repl, r_out_hit};

endmodule

// File: sv/lkt_checker.sv
// Port-level checks for the keyed entry table, bound to its top level.
// Depends on the port list of lru_keyed_entry_table_top only.
module lkt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // A stalled result keeps its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while stalled");

    // Only one item is in work: an accepted item closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    // A lookup never replaces and an insert never hits.
    a_hit_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("hit and replaced both set");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind lru_keyed_entry_table_top lkt_checker u_lkt_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench for lru_keyed_entry_table_top: directed and random lookup/insert items.
// Depends on lkt_pkg for ENTRIES and the opcode names; the expected results come from an
// in-bench copy of the LRU table behaviour.
`timescale 1ns / 100ps

module testbench;

    // One expected result item: the two tuser flags and the slot from tdata.
    typedef struct packed {
        logic       hit;
        logic [3:0] slot;
        logic       replaced;
    } t_table_result;

    // A directed stimulus row. Where fixed is set, want is the expected result typed in by
    // hand. Otherwise the row is checked against the in-bench table.
    typedef struct packed {
        logic          op;
        logic [63:0]   key;
        logic          fixed;
        t_table_result want;
    } t_dir_row;

    localparam int N_DIRECTED = 26;
    localparam int N_RANDOM   = 1324;
    localparam int POOL_SIZE  = 24;
    localparam int DRAIN_MAX  = 5000;
    localparam int TAIL_WAIT  = 40;

    localparam t_table_result NO_HIT = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;   // [63:0] key
    logic        i_s_axis_tuser = 1'b0; // [0] opcode
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;        // [3:0] slot, [7:4] zero
    logic [1:0]  o_m_axis_tuser;        // [0] hit, [1] replaced

    lru_keyed_entry_table_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the directory: keys, valid bits, recency ranks and fill level.
    // An age of 0 marks the most recently used slot.
    logic [63:0] tbl_key   [lkt_pkg::ENTRIES];
    logic        tbl_valid [lkt_pkg::ENTRIES];
    int          tbl_age   [lkt_pkg::ENTRIES];
    int          tbl_fill;

    t_table_result pending_results [$];

    // The item currently on the input carries its hand-typed expectation alongside it.
    logic          fixed_flag = 1'b0;
    t_table_result fixed_res  = '0;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int err_count   = 0;
    int n_lookups   = 0;
    int n_hits      = 0;
    int n_inserts   = 0;
    int n_evictions = 0;

    // Directed items. The first part runs on an empty table, where every answer is obvious.
    // Then the table is filled in slot order, and the last rows force the first evictions.
    // Those rows are left to the shadow table.
    t_dir_row directed_rows [N_DIRECTED] = '{
        // Lookups on an empty table miss and report slot 0.
        '{lkt_pkg::OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, NO_HIT},
        '{lkt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, NO_HIT},
        // The first inserts take the free slots in order and never report a hit.
        '{lkt_pkg::OP_INSERT, 64'h0000_0000_0000_0000, 1'b1, '{1'b0, 4'd0, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, 4'd1, 1'b0}},
        // A duplicate key is stored again without any check.
        '{lkt_pkg::OP_INSERT, 64'h0000_0000_0000_0000, 1'b1, '{1'b0, 4'd2, 1'b0}},
        // A lookup of the duplicated key reports the lowest slot that matches.
        '{lkt_pkg::OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b1, '{1'b1, 4'd0, 1'b0}},
        '{lkt_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 4'd1, 1'b0}},
        '{lkt_pkg::OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, NO_HIT},
        '{lkt_pkg::OP_LOOKUP, 64'h5555_5555_5555_5555, 1'b1, NO_HIT},
        // These fill the rest of the table.
        '{lkt_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 1'b1, '{1'b0, 4'd3, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h0000_0000_0000_0001, 1'b1, '{1'b0, 4'd4, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h0123_4567_89AB_CDEF, 1'b1, '{1'b0, 4'd5, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'hFEDC_BA98_7654_3210, 1'b1, '{1'b0, 4'd6, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h0000_0000_FFFF_FFFF, 1'b1, '{1'b0, 4'd7, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'hFFFF_FFFF_0000_0000, 1'b1, '{1'b0, 4'd8, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 1'b1, '{1'b0, 4'd9, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b0, 4'd10, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h00FF_00FF_00FF_00FF, 1'b1, '{1'b0, 4'd11, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'hFF00_FF00_FF00_FF00, 1'b1, '{1'b0, 4'd12, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h0000_0001_0000_0000, 1'b1, '{1'b0, 4'd13, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h8000_0000_0000_0001, 1'b1, '{1'b0, 4'd14, 1'b0}},
        '{lkt_pkg::OP_INSERT, 64'h3C3C_3C3C_3C3C_3C3C, 1'b1, '{1'b0, 4'd15, 1'b0}},
        // The table is full now, so each insert evicts the least recently used slot.
        '{lkt_pkg::OP_INSERT, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, NO_HIT},
        '{lkt_pkg::OP_LOOKUP, 64'h0000_0000_0000_0000, 1'b0, NO_HIT},
        '{lkt_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, NO_HIT},
        '{lkt_pkg::OP_LOOKUP, 64'h0F0F_0F0F_F0F0_F0F0, 1'b0, NO_HIT}
    };

    logic [63:0] key_pool [POOL_SIZE];

    // Make slot s the most recently used one. Every other valid slot that was used more
    // recently than limit moves one rank older.
    function automatic void promote_slot(input int s, input int limit);
        for (int i = 0; i < lkt_pkg::ENTRIES; i++) begin
            if (i != s && tbl_valid[i] && tbl_age[i] < limit)
                tbl_age[i]++;
        end
        tbl_age[s] = 0;
    endfunction

    // Apply one lookup or insert to the shadow table and return the result it should give.
    function automatic t_table_result lru_table_access(input logic op, input logic [63:0] key);
        t_table_result r;
        int            s;
        r = '0;
        s = 0;
        if (op == lkt_pkg::OP_LOOKUP) begin
            n_lookups++;
            for (int i = 0; i < lkt_pkg::ENTRIES; i++) begin
                if (!r.hit && tbl_valid[i] && tbl_key[i] == key) begin
                    r.hit = 1'b1;
                    s = i;
                end
            end
            if (r.hit) begin
                n_hits++;
                promote_slot(s, tbl_age[s]);
            end
        end else begin
            n_inserts++;
            if (tbl_fill < lkt_pkg::ENTRIES) begin
                s = tbl_fill;
                tbl_key[s] = key;
                tbl_valid[s] = 1'b1;
                promote_slot(s, 32'hFFFF);
                tbl_fill++;
            end else begin
                // The lowest slot with the greatest age is the eviction victim.
                for (int i = 1; i < lkt_pkg::ENTRIES; i++) begin
                    if (tbl_age[i] > tbl_age[s])
                        s = i;
                end
                tbl_key[s] = key;
                tbl_valid[s] = 1'b1;
                promote_slot(s, tbl_age[s]);
                r.replaced = 1'b1;
                n_evictions++;
            end
        end
        r.slot = s[3:0];
        return r;
    endfunction

    // Put one item on the input channel and hold it until it is accepted. Valid is left high
    // afterwards, so that an item which follows at once does not lower and raise it at
    // the same edge.
    task automatic send_item(input logic op, input logic [63:0] key, input logic fixed,
                             input t_table_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= key;
        i_s_axis_tuser  <= op;
        fixed_flag      <= fixed;
        fixed_res       <= want;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Input monitor. Every accepted item updates the shadow table, which stays in step
    // with the block even for rows whose expectation was typed in by hand.
    always @(posedge i_clk) begin
        t_table_result r;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            r = lru_table_access(i_s_axis_tuser, i_s_axis_tdata);
            pending_results.push_back(fixed_flag ? fixed_res : r);
        end
    end

    // Output side. Check the result item that is accepted at this edge, then pick the ready
    // level for the next cycle.
    always @(posedge i_clk) begin
        t_table_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %b",
                       o_m_axis_tdata, o_m_axis_tuser);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser[0] !== want.hit) begin
                    $error("hit mismatch: expected %0d, got %0d", want.hit, o_m_axis_tuser[0]);
                    err_count++;
                end
                if (o_m_axis_tdata[3:0] !== want.slot) begin
                    $error("slot mismatch: expected %0d, got %0d", want.slot,
                           o_m_axis_tdata[3:0]);
                    err_count++;
                end
                if (o_m_axis_tuser[1] !== want.replaced) begin
                    $error("replaced mismatch: expected %0d, got %0d", want.replaced,
                           o_m_axis_tuser[1]);
                    err_count++;
                end
                if (o_m_axis_tdata[7:4] !== 4'd0) begin
                    $error("tdata padding mismatch: expected 0, got %h", o_m_axis_tdata[7:4]);
                    err_count++;
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard limit. The slowest correct run stays far below this.
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int          waited;
        int          phase;
        logic        op;
        logic [63:0] key;
        int          pick;

        for (int i = 0; i < lkt_pkg::ENTRIES; i++) begin
            tbl_key[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_age[i]   = 0;
        end
        tbl_fill = 0;
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = {$urandom, $urandom};

        tx_idle_pct = 17;
        rx_idle_pct = 48;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].fixed,
                      directed_rows[i].want);

        // Random part in three nearly equal phases of idling. Most keys are drawn from a small
        // pool, so that lookups hit often and inserts keep creating duplicates.
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = n * 3 / N_RANDOM;
            tx_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 48 : 0;
            rx_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 17 : 0;

            op = ($urandom_range(99) < 40) ? lkt_pkg::OP_INSERT : lkt_pkg::OP_LOOKUP;
            pick = $urandom_range(99);
            if (pick < 75) begin
                key = key_pool[$urandom_range(POOL_SIZE - 1)];
            end else if (pick < 80) begin
                key = ($urandom_range(1) != 0) ? '1 : '0;
            end else begin
                key = {$urandom, $urandom};
                // A fresh key that gets stored joins the pool, so it can be looked up later.
                if (op == lkt_pkg::OP_INSERT)
                    key_pool[$urandom_range(POOL_SIZE - 1)] = key;
            end
            send_item(op, key, 1'b0, NO_HIT);
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain the results still outstanding, then watch a little longer for stray items.
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result items never arrived", pending_results.size());
            err_count++;
        end

        $display("Ran %0d items: %0d lookups (%0d hits), %0d inserts (%0d evictions).",
                 N_DIRECTED + N_RANDOM, n_lookups, n_hits, n_inserts, n_evictions);
        $display("Sender/receiver idle mix went 17/48, 48/17, then 0/0 percent.");
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
sv/lkt_pkg.sv
sv/lkt_key_ram.sv
sv/lru_keyed_entry_table_top.sv
sv/lkt_checker.sv
tb/testbench.sv
